[hw/rtl/prq_pkg.sv]
// Package for the page recency queue: beat structs, operation codes and the
// per-cell control bundle. Used by prq_cell and page_recency_queue.
`default_nettype none

package prq_pkg;

  localparam int unsigned PageW        = 16;
  localparam int unsigned OccW         = 5;
  localparam int unsigned DefaultDepth = 16;

  typedef enum logic [1:0] {
    OpPush = 2'd0,
    OpPop  = 2'd1,
    OpMove = 2'd2
  } prq_op_e;

  typedef struct packed {
    logic [1:0]       operation;
    logic [PageW-1:0] page;
  } prq_in_t;

  typedef struct packed {
    logic [PageW-1:0] page_out;
    logic             empty_flag;
    logic             full_flag;
    logic             found_flag;
    logic [OccW-1:0]  occupancy;
  } prq_out_t;

  typedef struct packed {
    logic             go;
    logic [1:0]       op;
    logic [PageW-1:0] page;
    logic             live;
    logic             tail;
    logic             head;
  } prq_cell_ctl_t;

endpackage

`default_nettype wire

[hw/rtl/prq_cell.sv]
// One slot of the page recency queue chain. Holds a page, compares it with the
// requested page and takes its right neighbor's page on a shift. Uses prq_pkg.
`default_nettype none

module prq_cell
  import prq_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire prq_cell_ctl_t        ctl_i,
  input  wire logic [PageW-1:0]     next_slot_i,
  input  wire logic                 seen_i,
  output logic                      seen_o,
  output logic [PageW-1:0]          slot_o
);

  logic [PageW-1:0] slot_q;
  logic [PageW-1:0] slot_d;
  logic             match;

  assign match  = ctl_i.live && (slot_q == ctl_i.page);
  assign seen_o = seen_i || match;
  assign slot_o = slot_q;

  always_comb begin
    slot_d = slot_q;
    if (ctl_i.go) begin
      case (ctl_i.op)
        OpPush: begin
          if (ctl_i.head) begin
            slot_d = ctl_i.page;
          end
        end
        OpPop: begin
          slot_d = next_slot_i;
        end
        OpMove: begin
          if (seen_o && ctl_i.live) begin
            slot_d = ctl_i.tail ? ctl_i.page : next_slot_i;
          end
        end
        default: begin
          slot_d = slot_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

endmodule

`default_nettype wire

[hw/rtl/page_recency_queue.sv]
// Page recency queue top level: a chain of prq_cell slots, the fill count and
// the result register. Uses prq_pkg and prq_cell.
//
// Each input beat carries an operation and a page number. Push appends the
// page at the back, pop removes and returns the front page, and move finds
// the frontmost copy of the page and moves it to the back. Every input beat
// gives exactly one output beat with the popped page, the empty, full and
// found flags and the occupancy after the operation.
// All cells compare and shift in the same cycle, so an item is finished in
// the cycle it is accepted and its registered result appears in the next.
// A new beat can be accepted every cycle unless the receiver stalls; the
// rate is set by the single result register and the match ripple in the chain.
// When the receiver stalls, the result register holds its beat and in_stall_o
// rises, so no further input beat is accepted until the result is taken.
// Reset empties the queue and clears the output valid; slot contents are
// not cleared because entries at or beyond the fill count are never read.
`default_nettype none

module page_recency_queue
  import prq_pkg::*;
#(
  parameter int unsigned Depth = DefaultDepth
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire prq_in_t  in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output prq_out_t      out_data_o
);

  localparam int unsigned CntW = $clog2(Depth + 1);

  logic                  accept;
  logic [CntW-1:0]       count_q;
  logic [CntW-1:0]       count_d;
  logic                  is_empty;
  logic                  is_full;
  logic                  out_valid_q;
  logic                  out_valid_d;
  prq_out_t              out_q;
  prq_out_t              out_d;
  logic [Depth:0]        seen;
  logic [PageW-1:0]      slot [Depth];
  logic [PageW-1:0]      next_slot [Depth];
  prq_cell_ctl_t         ctl [Depth];

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign is_empty   = (count_q == '0);
  assign is_full    = (count_q == CntW'(Depth));
  assign seen[0]    = 1'b0;

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    assign ctl[i].go   = accept;
    assign ctl[i].op   = in_data_i.operation;
    assign ctl[i].page = in_data_i.page;
    assign ctl[i].live = (CntW'(i) < count_q);
    assign ctl[i].tail = (count_q == CntW'(i + 1));
    assign ctl[i].head = (count_q == CntW'(i));

    if (i == Depth - 1) begin : g_last
      assign next_slot[i] = slot[i];
    end else begin : g_mid
      assign next_slot[i] = slot[i+1];
    end

    prq_cell u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl[i]),
      .next_slot_i (next_slot[i]),
      .seen_i      (seen[i]),
      .seen_o      (seen[i+1]),
      .slot_o      (slot[i])
    );
  end

  always_comb begin
    count_d = count_q;
    out_d   = '0;
    case (in_data_i.operation)
      OpPush: begin
        if (is_full) begin
          out_d.full_flag = 1'b1;
        end else begin
          count_d = count_q + CntW'(1);
        end
      end
      OpPop: begin
        if (is_empty) begin
          out_d.empty_flag = 1'b1;
        end else begin
          out_d.page_out = slot[0];
          count_d        = count_q - CntW'(1);
        end
      end
      OpMove: begin
        out_d.found_flag = seen[Depth];
      end
      default: begin
        count_d = count_q;
      end
    endcase
    out_d.occupancy = OccW'(count_d);
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (accept) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("Fill count exceeds the queue depth.");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (in_data_i.operation == OpPush) && !is_full
      |=> count_q == $past(count_q) + CntW'(1))
    else $error("Accepted push did not grow the queue.");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.empty_flag |-> is_empty && (out_data_o.page_out == '0))
    else $error("Empty flag raised while the queue holds pages.");

  a_stall_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("Input stalled with no result waiting.");

endmodule

`default_nettype wire

[dv/tb_page_recency_queue.sv]
// Testbench for page_recency_queue: directed corner cases, then random push, pop and move
// traffic under several idle and stall patterns, checked beat by beat against a queue model.
// Depends on prq_pkg and the page_recency_queue RTL.
`default_nettype none

module tb_page_recency_queue;
  import prq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Depth         = DefaultDepth;
  localparam logic [1:0]  OpUnused      = 2'd3;
  localparam int          WatchdogLimit = 2000;
  localparam int          PoolSize      = 12;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_stall_o;
  prq_in_t  in_data_i   = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  prq_out_t out_data_o;

  logic [PageW-1:0] held_pages[$];
  prq_out_t         results_due[$];
  logic [PageW-1:0] page_pool[PoolSize];
  int               mismatches    = 0;
  int               quiet_cycles  = 0;
  int               send_idle_pct = 0;
  int               stall_pct     = 0;

  page_recency_queue #(
    .Depth(Depth)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic prq_out_t apply_page_op(prq_in_t beat);
    prq_out_t res;
    int       hit;
    res = '0;
    hit = -1;
    case (beat.operation)
      OpPush: begin
        if (held_pages.size() >= Depth) res.full_flag = 1'b1;
        else held_pages.push_back(beat.page);
      end
      OpPop: begin
        if (held_pages.size() == 0) res.empty_flag = 1'b1;
        else res.page_out = held_pages.pop_front();
      end
      OpMove: begin
        for (int i = 0; i < held_pages.size(); i++) begin
          if (hit < 0 && held_pages[i] == beat.page) hit = i;
        end
        if (hit >= 0) begin
          res.found_flag = 1'b1;
          held_pages.delete(hit);
          held_pages.push_back(beat.page);
        end
      end
      default: ;
    endcase
    res.occupancy = OccW'(held_pages.size());
    return res;
  endfunction

  task automatic compare_result(input prq_out_t want, input prq_out_t got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display({"Mismatch: expected page %h empty %b full %b found %b occ %0d,",
                  " got page %h empty %b full %b found %b occ %0d"},
                 want.page_out, want.empty_flag, want.full_flag, want.found_flag,
                 want.occupancy, got.page_out, got.empty_flag, got.full_flag,
                 got.found_flag, got.occupancy);
      end
    end
  endtask

  // Results are checked before the new input beat is applied to the model.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (results_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected result beat: page %h occ %0d",
                                         out_data_o.page_out, out_data_o.occupancy);
        end else begin
          compare_result(results_due.pop_front(), out_data_o);
        end
      end
      if (in_valid_i && !in_stall_o) results_due.push_back(apply_page_op(in_data_i));
    end
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_beat(input logic [1:0] op, input logic [PageW-1:0] page);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{operation: op, page: page};
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic test_special_cases();
    send_beat(OpPop, 16'h0000);
    send_beat(OpUnused, 16'hFFFF);
    send_beat(OpMove, 16'h0000);
    send_beat(OpPush, 16'h0000);
    send_beat(OpPush, 16'hFFFF);
    send_beat(OpPush, 16'h0000);
    send_beat(OpMove, 16'h0000);
    send_beat(OpMove, 16'hFFFF);
    send_beat(OpMove, 16'hFFFF);
    send_beat(OpMove, 16'h1234);
    for (int i = 0; i < Depth - 3; i++) send_beat(OpPush, 16'h8000 >> i);
    send_beat(OpPush, 16'h5A5A);
    send_beat(OpMove, 16'h0000);
    send_beat(OpPop, 16'hFFFF);
    send_beat(OpPop, 16'h0000);
  endtask

  task automatic test_drain_pause();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (results_due.size() != 0);
  endtask

  task automatic test_random_traffic(input int n_items, input int idle_pct,
                                     input int recv_stall_pct);
    int               burst_left;
    int               push_share;
    int               roll;
    logic [1:0]       op;
    logic [PageW-1:0] page;
    burst_left     = 0;
    push_share     = 50;
    send_idle_pct  = idle_pct;
    stall_pct      = recv_stall_pct;
    foreach (page_pool[i]) page_pool[i] = PageW'($urandom);
    for (int k = 0; k < n_items; k++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(40, 10);
        push_share = $urandom_range(1) ? 75 : 25;
      end
      burst_left--;
      roll = $urandom_range(99);
      if (roll < 3) op = OpUnused;
      else if (roll < 3 + push_share * 97 / 100) op = OpPush;
      else if (roll < 3 + (push_share + (100 - push_share) / 2) * 97 / 100) op = OpPop;
      else op = OpMove;
      if ($urandom_range(99) < 70) page = page_pool[$urandom_range(PoolSize - 1)];
      else page = PageW'($urandom);
      send_beat(op, page);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_special_cases();
    test_drain_pause();
    test_random_traffic(340, 0, 0);
    test_random_traffic(340, 73, 0);
    test_drain_pause();
    test_random_traffic(340, 0, 73);
    test_random_traffic(340, 26, 26);
    test_drain_pause();
    repeat (4) @(posedge clk_i);
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
